FILE: rtl/bsad_pkg.sv
// shared types and constants for the bank switched address decoder
`default_nettype none
package bsad_pkg;

  typedef enum logic [2:0] {
    TGT_RAM    = 3'd0,
    TGT_BASIC  = 3'd1,
    TGT_KERNAL = 3'd2,
    TGT_CHAR   = 3'd3,
    TGT_VIDEO  = 3'd4,
    TGT_SOUND  = 3'd5,
    TGT_TIMERS = 3'd6,
    TGT_IO     = 3'd7
  } target_t;

  localparam logic [7:0]  BANK_RESET   = 8'h37;
  localparam logic [15:0] BANK_ADDR    = 16'h0001;
  localparam logic [2:0]  IO_BIT_MASK  = 3'h4;
  localparam logic [2:0]  BANK_MASK    = 3'h7;
  localparam logic [15:0] BASIC_BASE   = 16'ha000;
  localparam logic [15:0] BASIC_LIMIT  = 16'hc000;
  localparam logic [15:0] IO_BASE      = 16'hd000;
  localparam logic [15:0] SOUND_BASE   = 16'hd400;
  localparam logic [15:0] AREA_BASE    = 16'hd800;
  localparam logic [15:0] TIMER_BASE   = 16'hdc00;
  localparam logic [15:0] SOUND2_BASE  = 16'hde00;
  localparam logic [15:0] SOUND2_END   = 16'hdf00;
  localparam logic [15:0] KERNAL_BASE  = 16'he000;

  // one bus access with the bank byte in effect for it
  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  bank;
  } access_t;

  typedef struct packed {
    target_t     target;
    logic [15:0] target_address;
    logic        ram_also_written;
    logic [7:0]  bank_value;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/bsad_in_if.sv
// handshake channel carrying one bus access word
`default_nettype none
interface bsad_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output op, output address, output write_data, input ready);
  modport sink   (input valid, input op, input address, input write_data, output ready);
endinterface
`default_nettype wire

FILE: rtl/bsad_out_if.sv
// handshake channel carrying one decode result word
`default_nettype none
interface bsad_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [15:0] target_address;
  logic        ram_also_written;
  logic [7:0]  bank_value;

  modport source (output valid, output target, output target_address,
                  output ram_also_written, output bank_value, input ready);
  modport sink   (input valid, input target, input target_address,
                  input ram_also_written, input bank_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/bsad_decode.sv
// combinational target decode of one access against its bank byte
`default_nettype none
module bsad_decode (
  input  wire bsad_pkg::access_t acc,
  output bsad_pkg::result_t      res
);

  logic [15:0] a;
  logic [7:0]  b;
  logic        io_vis;

  assign a = acc.address;
  assign b = acc.bank;
  assign io_vis = (b[2:0] & bsad_pkg::IO_BIT_MASK) != 3'h0 &&
                  (b[2:0] & bsad_pkg::BANK_MASK) != bsad_pkg::IO_BIT_MASK;

  always_comb begin
    res.target           = bsad_pkg::TGT_RAM;
    res.target_address   = a;
    res.ram_also_written = acc.op;
    res.bank_value       = b;
    if (a >= bsad_pkg::IO_BASE && a < bsad_pkg::KERNAL_BASE) begin
      if (io_vis) begin
        res.ram_also_written = 1'b0;
        if (a < bsad_pkg::SOUND_BASE) begin
          res.target = bsad_pkg::TGT_VIDEO;
        end else if (a < bsad_pkg::AREA_BASE) begin
          res.target = bsad_pkg::TGT_SOUND;
        end else if (a >= bsad_pkg::TIMER_BASE && a < bsad_pkg::SOUND2_BASE) begin
          // timer writes also land in ram
          res.target           = bsad_pkg::TGT_TIMERS;
          res.ram_also_written = acc.op;
        end else if (a >= bsad_pkg::SOUND2_BASE && a < bsad_pkg::SOUND2_END) begin
          res.target = bsad_pkg::TGT_SOUND;
        end else begin
          res.target         = bsad_pkg::TGT_IO;
          res.target_address = a - bsad_pkg::IO_BASE;
        end
      end else if (!acc.op && !b[2] && b[1:0] != 2'b00) begin
        res.target         = bsad_pkg::TGT_CHAR;
        res.target_address = a - bsad_pkg::IO_BASE;
      end
    end else if (!acc.op) begin
      // roms are only seen by reads
      if (a >= bsad_pkg::BASIC_BASE && a < bsad_pkg::BASIC_LIMIT && b[1:0] == 2'b11) begin
        res.target         = bsad_pkg::TGT_BASIC;
        res.target_address = a - bsad_pkg::BASIC_BASE;
      end else if (a >= bsad_pkg::KERNAL_BASE && b[1]) begin
        res.target         = bsad_pkg::TGT_KERNAL;
        res.target_address = a - bsad_pkg::KERNAL_BASE;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bank_switched_address_decoder.sv
// bank switched address decoder: two stage decode with bank byte tracking
// each access is registered in stage 1, decoded, and then registered in the result stage, which offers the result word
// throughput: one access per cycle while the result is taken, result ready passes straight back to access ready
// the bank byte is applied in acceptance order and updates on writes to address 1
// reset: bank byte 0x37, both pipeline stages empty
`default_nettype none
module bank_switched_address_decoder (
  input  wire logic  clk,
  input  wire logic  rst,
  bsad_in_if.sink    access,
  bsad_out_if.source result
);

  logic               s1_valid;
  bsad_pkg::access_t  s1;
  logic [7:0]         bank;
  logic               out_valid;
  bsad_pkg::result_t  out;
  bsad_pkg::result_t  dec;
  logic               out_free;
  logic               s1_move;
  logic               take;

  assign out_free = !out_valid || result.ready;
  assign s1_move  = s1_valid && out_free;
  assign access.ready = !s1_valid || out_free;
  assign take = access.valid && access.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank      <= bsad_pkg::BANK_RESET;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take && access.op && access.address == bsad_pkg::BANK_ADDR) begin
        bank <= access.write_data;
      end
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, bank captured before any update from this word
  always_ff @(posedge clk) begin
    if (take) begin
      s1.op      <= access.op;
      s1.address <= access.address;
      s1.bank    <= bank;
    end
    if (s1_move) begin
      out <= dec;
    end
  end

  bsad_decode u_decode (
    .acc (s1),
    .res (dec)
  );

  assign result.valid            = out_valid;
  assign result.target           = out.target;
  assign result.target_address   = out.target_address;
  assign result.ram_also_written = out.ram_also_written;
  assign result.bank_value       = out.bank_value;

endmodule
`default_nettype wire

FILE: tb/sv/bank_switched_address_decoder_test.sv
// self-checking testbench for the bank switched address decoder
module bank_switched_address_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  localparam int RANDOM_WORDS = 550;
  localparam int QUIET_FROM   = 500;
  localparam int HOLD_CYCLES  = 48;
  localparam int CYCLE_LIMIT  = 100000;

  // holds the bank byte and the decodes still owed by the block
  class access_scoreboard;
    logic [7:0]          bank;
    bsad_pkg::result_t   decode_q[$];
    int unsigned errors;
    int unsigned decoded;
    int unsigned bank_writes;
    int unsigned target_hits[8];

    function new();
      bank = bsad_pkg::BANK_RESET;
    endfunction

    function bsad_pkg::result_t decode_access(logic wr, logic [15:0] a, logic [7:0] b);
      bsad_pkg::result_t r;
      logic              io_on;
      io_on = ((b[2:0] & bsad_pkg::IO_BIT_MASK) != 3'h0) &&
              ((b[2:0] & bsad_pkg::BANK_MASK) != bsad_pkg::IO_BIT_MASK);
      r.target = bsad_pkg::TGT_RAM;
      r.target_address = a;
      r.ram_also_written = wr;
      r.bank_value = b;
      if (a >= bsad_pkg::IO_BASE && a < bsad_pkg::KERNAL_BASE) begin
        if (io_on) begin
          r.ram_also_written = 1'b0;
          if (a < bsad_pkg::SOUND_BASE) begin
            r.target = bsad_pkg::TGT_VIDEO;
          end else if (a < bsad_pkg::AREA_BASE) begin
            r.target = bsad_pkg::TGT_SOUND;
          end else if (a >= bsad_pkg::TIMER_BASE && a < bsad_pkg::SOUND2_BASE) begin
            // timer writes land in ram as well
            r.target = bsad_pkg::TGT_TIMERS;
            r.ram_also_written = wr;
          end else if (a >= bsad_pkg::SOUND2_BASE && a < bsad_pkg::SOUND2_END) begin
            r.target = bsad_pkg::TGT_SOUND;
          end else begin
            r.target = bsad_pkg::TGT_IO;
            r.target_address = a - bsad_pkg::IO_BASE;
          end
        end else if (!wr && (b[2:0] & bsad_pkg::IO_BIT_MASK) == 3'h0 &&
                     b[1:0] != 2'b00) begin
          r.target = bsad_pkg::TGT_CHAR;
          r.target_address = a - bsad_pkg::IO_BASE;
        end
      end else if (!wr) begin
        // roms are only seen by reads
        if (a >= bsad_pkg::BASIC_BASE && a < bsad_pkg::BASIC_LIMIT && b[1:0] == 2'b11) begin
          r.target = bsad_pkg::TGT_BASIC;
          r.target_address = a - bsad_pkg::BASIC_BASE;
        end else if (a >= bsad_pkg::KERNAL_BASE && b[1]) begin
          r.target = bsad_pkg::TGT_KERNAL;
          r.target_address = a - bsad_pkg::KERNAL_BASE;
        end
      end
      return r;
    endfunction

    function void note_access(logic wr, logic [15:0] a, logic [7:0] d);
      decode_q.push_back(decode_access(wr, a, bank));
      // decoded with the old bank byte, then the byte is replaced
      if (wr && a == bsad_pkg::BANK_ADDR) begin
        bank = d;
        bank_writes++;
      end
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    task check_result(bsad_pkg::result_t got);
      bsad_pkg::result_t want;
      if (decode_q.size() == 0) begin
        report("unexpected word, target", 16'(got.target), 16'h0);
      end else begin
        want = decode_q.pop_front();
        decoded++;
        target_hits[want.target]++;
        if (got.target != want.target)
          report("target", 16'(got.target), 16'(want.target));
        if (got.target_address != want.target_address)
          report("target_address", got.target_address, want.target_address);
        if (got.ram_also_written != want.ram_also_written)
          report("ram_also_written", 16'(got.ram_also_written), 16'(want.ram_also_written));
        if (got.bank_value != want.bank_value)
          report("bank_value", 16'(got.bank_value), 16'(want.bank_value));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int unsigned words_in;
  int unsigned words_out;
  int unsigned cycles;
  access_scoreboard book;

  bsad_in_if  acc_if ();
  bsad_out_if res_if ();

  bank_switched_address_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .access (acc_if.sink),
    .result (res_if.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycles, book.decode_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    bsad_pkg::result_t got;
    if (!rst) begin
      if (acc_if.valid && acc_if.ready) begin
        book.note_access(acc_if.op, acc_if.address, acc_if.write_data);
        words_in++;
      end
      if (res_if.valid && res_if.ready) begin
        got.target = bsad_pkg::target_t'(res_if.target);
        got.target_address = res_if.target_address;
        got.ram_also_written = res_if.ram_also_written;
        got.bank_value = res_if.bank_value;
        book.check_result(got);
        words_out++;
      end
    end
  end

  // receiver: short random stalls, plus two long hold-offs to back up the pipe
  initial begin : receiver
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned holds_done;
    stall_left = 0;
    hold_left = 0;
    holds_done = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < 2 && words_out >= 60 + holds_done * 240) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (words_in < QUIET_FROM && $urandom_range(0, 4) == 0)
          stall_left = $urandom_range(1, 3);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_access(input logic wr, input logic [15:0] a, input logic [7:0] d);
    int unsigned gap;
    acc_if.valid <= 1'b1;
    acc_if.op <= wr;
    acc_if.address <= a;
    acc_if.write_data <= d;
    do @(posedge clk); while (!acc_if.ready);
    @(negedge clk);
    if (words_in < QUIET_FROM && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      acc_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic run_random_accesses(input int count);
    logic        wr;
    logic [15:0] a;
    logic [7:0]  d;
    for (int i = 0; i < count; i++) begin
      wr = 1'($urandom_range(0, 1));
      d = 8'($urandom);
      case ($urandom_range(0, 8))
        0: begin
          // bank switch with a random byte
          wr = OP_WRITE;
          a = bsad_pkg::BANK_ADDR;
        end
        1: a = bsad_pkg::BASIC_BASE + 16'($urandom_range(0, 16'h1fff));
        2: a = bsad_pkg::KERNAL_BASE + 16'($urandom_range(0, 16'h1fff));
        3, 4: a = bsad_pkg::IO_BASE + 16'($urandom_range(0, 16'h0fff));
        5: begin
          case ($urandom_range(0, 11))
            0: a = 16'hd000;
            1: a = 16'hd3ff;
            2: a = 16'hd400;
            3: a = 16'hd7ff;
            4: a = 16'hd800;
            5: a = 16'hdbff;
            6: a = 16'hdc00;
            7: a = 16'hddff;
            8: a = 16'hde00;
            9: a = 16'hdeff;
            10: a = 16'hdf00;
            default: a = 16'hdfff;
          endcase
        end
        6: begin
          case ($urandom_range(0, 6))
            0: a = 16'h9fff;
            1: a = 16'ha000;
            2: a = 16'hbfff;
            3: a = 16'hc000;
            4: a = 16'hcfff;
            5: a = 16'he000;
            default: a = 16'hffff;
          endcase
        end
        7: a = 16'($urandom_range(0, 3));
        default: a = 16'($urandom);
      endcase
      send_access(wr, a, d);
    end
  endtask

  initial begin
    book = new();
    rst = 1'b1;
    acc_if.valid = 1'b0;
    acc_if.op = OP_READ;
    acc_if.address = 16'h0000;
    acc_if.write_data = 8'h00;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset bank byte: accesses at region edges
    send_access(OP_READ,  16'h0000, 8'h00);
    send_access(OP_READ,  16'hffff, 8'hff);
    send_access(OP_READ,  16'ha000, 8'h00);
    send_access(OP_READ,  16'hbfff, 8'h00);
    send_access(OP_READ,  16'hc000, 8'h00);
    send_access(OP_READ,  16'hd000, 8'h00);
    send_access(OP_READ,  16'hd7ff, 8'h00);
    send_access(OP_READ,  16'hd800, 8'h00);
    send_access(OP_READ,  16'hdc00, 8'h00);
    send_access(OP_WRITE, 16'hddff, 8'hff);
    send_access(OP_READ,  16'hde00, 8'h00);
    send_access(OP_WRITE, 16'hdfff, 8'h5a);
    send_access(OP_WRITE, 16'ha000, 8'ha5);
    // char rom mapped in, io hidden
    send_access(OP_WRITE, bsad_pkg::BANK_ADDR, 8'h33);
    send_access(OP_READ,  16'hd000, 8'h00);
    send_access(OP_WRITE, 16'hd000, 8'h12);
    send_access(OP_READ,  16'ha000, 8'h00);
    // all ram with 0x34, then 0xff maps io and kernal, 0x00 all ram again
    send_access(OP_WRITE, bsad_pkg::BANK_ADDR, 8'h34);
    send_access(OP_READ,  16'hd400, 8'h00);
    send_access(OP_WRITE, bsad_pkg::BANK_ADDR, 8'hff);
    send_access(OP_READ,  16'he000, 8'h00);
    send_access(OP_READ,  16'hd000, 8'h00);
    send_access(OP_WRITE, bsad_pkg::BANK_ADDR, 8'h00);
    send_access(OP_READ,  16'hffff, 8'h00);
    send_access(OP_READ,  bsad_pkg::BANK_ADDR, 8'hff);
    send_access(OP_WRITE, bsad_pkg::BANK_ADDR, 8'h37);

    run_random_accesses(RANDOM_WORDS);
    acc_if.valid <= 1'b0;

    while (book.decode_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d decodes across %0d bank byte changes, %0d mismatches",
             book.decoded, book.bank_writes, book.errors);
    $display("targets: ram %0d basic %0d kernal %0d char %0d",
             book.target_hits[bsad_pkg::TGT_RAM], book.target_hits[bsad_pkg::TGT_BASIC],
             book.target_hits[bsad_pkg::TGT_KERNAL], book.target_hits[bsad_pkg::TGT_CHAR]);
    $display("targets: video %0d sound %0d timers %0d io %0d",
             book.target_hits[bsad_pkg::TGT_VIDEO], book.target_hits[bsad_pkg::TGT_SOUND],
             book.target_hits[bsad_pkg::TGT_TIMERS], book.target_hits[bsad_pkg::TGT_IO]);
    if (book.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
rtl/bsad_pkg.sv
rtl/bsad_in_if.sv
rtl/bsad_out_if.sv
rtl/bsad_decode.sv
rtl/bank_switched_address_decoder.sv
tb/sv/bank_switched_address_decoder_test.sv
